// ===== hw/rtl/spp_pkg.sv =====
// ----------------------------------------------------------------------------
// spp_pkg
// Shared constants for the servo potentiometer pulse conditioner: register
// indexes, reset values and the fixed scaling of the angle and pulse maps.
// ----------------------------------------------------------------------------
package spp_pkg;

  // Default sample width of the converter stream
  localparam int SAMPLE_BITS_DEF = 12;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTHING_SHIFT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_DEADBAND  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_DEADBAND  = 2'd2;

  // Register widths and reset values
  localparam int SHIFT_W    = 3;
  localparam int LEVEL_DB_W = 12;
  localparam int PULSE_DB_W = 11;

  localparam logic [SHIFT_W-1:0]    SHIFT_RESET    = 3'd3;
  localparam logic [LEVEL_DB_W-1:0] LEVEL_DB_RESET = 12'd12;
  localparam logic [PULSE_DB_W-1:0] PULSE_DB_RESET = 11'd8;

  // Headroom of the averaging accumulator over the sample width
  localparam int ACC_EXTRA = 7;

  // Result field widths
  localparam int PULSE_W  = 12;
  localparam int ANGLE_W  = 8;
  localparam int LEVEL_W  = 12;
  localparam int OUT_DATA_W = 32;

  // Angle and pulse map
  localparam logic [ANGLE_W-1:0] ANGLE_MAX    = 8'd180;
  localparam logic [PULSE_W-1:0] PULSE_MIN    = 12'd500;
  localparam logic [PULSE_W-1:0] PULSE_MAX    = 12'd2500;
  localparam logic [PULSE_W-1:0] PULSE_CENTRE = 12'd1500;

  // angle * 2000 / 180 == floor(angle * 1456400 / 2^17) for angle <= 180
  localparam int PULSE_MUL_W = 21;
  localparam int PULSE_PROD_W = ANGLE_W + PULSE_MUL_W;
  localparam logic [PULSE_MUL_W-1:0] PULSE_MUL = 21'd1456400;
  localparam int PULSE_MUL_SHIFT = 17;

endpackage

// ===== hw/rtl/servo_pot_pulse_conditioner.sv =====
// ----------------------------------------------------------------------------
// servo_pot_pulse_conditioner
// Smooths potentiometer samples, applies level and pulse deadbands and maps
// the held level to a servo angle and pulse width.
// ----------------------------------------------------------------------------
// Takes one sample per clock while no stage stalls and returns one result
// per sample, in order. The pipeline has four registered stages: the input
// register, the averaging stage (accumulator and held level update in the
// same cycle), the angle stage (constant multiply and divide by full scale)
// and the output register (pulse map and held pulse update). Each stage
// holds its item until the next stage can take it, so empty stages keep
// filling while a result waits on out_tready. Configuration writes take
// effect at the next edge and are meant for an idle pipeline.
module servo_pot_pulse_conditioner #(
  parameter int SAMPLE_BITS = spp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port
  input  logic                                cfg_wr_en,
  input  logic [spp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [spp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Sample stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [SAMPLE_BITS-1:0] sample, zero padded to whole bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [11:0] pulse_width, [19:12] angle_degrees, [31:20] smoothed_level
  output logic [spp_pkg::OUT_DATA_W-1:0]      out_tdata,
  // [0] pulse_changed
  output logic                                out_tuser
);

  localparam int ACC_W  = SAMPLE_BITS + spp_pkg::ACC_EXTRA;
  localparam int CMP_W  = (SAMPLE_BITS > spp_pkg::LEVEL_DB_W) ? SAMPLE_BITS
                                                              : spp_pkg::LEVEL_DB_W;
  localparam int PROD_W = SAMPLE_BITS + spp_pkg::ANGLE_W;
  localparam int FMT_W  = SAMPLE_BITS + spp_pkg::LEVEL_W;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
  localparam logic [ACC_W-1:0]       ACC_MAX    = {FULL_SCALE, 7'b0};
  localparam logic [SAMPLE_BITS:0]   FS_EXT     = {1'b0, FULL_SCALE};

  // Configuration registers
  logic [spp_pkg::SHIFT_W-1:0]    shift_r;
  logic [spp_pkg::LEVEL_DB_W-1:0] level_db_r;
  logic [spp_pkg::PULSE_DB_W-1:0] pulse_db_r;

  // Pipeline registers
  logic                        s0_valid_r;
  logic [SAMPLE_BITS-1:0]      s0_sample_r;
  logic                        s1_valid_r;
  logic [SAMPLE_BITS-1:0]      s1_smoothed_r;
  logic                        s2_valid_r;
  logic [spp_pkg::ANGLE_W-1:0] s2_angle_r;
  logic [spp_pkg::LEVEL_W-1:0] s2_smoothed_r;
  logic                        out_valid_r;
  logic                        out_changed_r;
  logic [spp_pkg::ANGLE_W-1:0] out_angle_r;
  logic [spp_pkg::LEVEL_W-1:0] out_smoothed_r;

  // Running state
  logic [ACC_W-1:0]            acc_r;
  logic [SAMPLE_BITS-1:0]      held_level_r;
  logic [spp_pkg::PULSE_W-1:0] held_pulse_r;

  // Stage handshakes
  logic out_rdy, s2_rdy, s1_rdy, s0_rdy;
  logic s0_load, s1_load, s2_load, out_load;

  assign out_rdy  = !out_valid_r || out_tready;
  assign s2_rdy   = !s2_valid_r || out_rdy;
  assign s1_rdy   = !s1_valid_r || s2_rdy;
  assign s0_rdy   = !s0_valid_r || s1_rdy;
  assign in_tready = s0_rdy;

  assign s0_load  = in_tvalid && s0_rdy;
  assign s1_load  = s0_valid_r && s1_rdy;
  assign s2_load  = s1_valid_r && s2_rdy;
  assign out_load = s2_valid_r && out_rdy;

  // Averaging stage: update accumulator, saturate, apply level deadband
  logic [ACC_W-1:0]       samp_ext;
  logic [ACC_W-1:0]       acc_seed;
  logic [ACC_W:0]         acc_sum;
  logic [ACC_W-1:0]       acc_nxt;
  logic [ACC_W-1:0]       acc_scaled;
  logic [SAMPLE_BITS-1:0] smoothed;
  logic [SAMPLE_BITS-1:0] level_base;
  logic [SAMPLE_BITS-1:0] level_diff;
  logic [CMP_W-1:0]       level_diff_ext;
  logic [CMP_W-1:0]       level_db_ext;
  logic [SAMPLE_BITS-1:0] held_level_nxt;

  always_comb begin
    samp_ext   = {{spp_pkg::ACC_EXTRA{1'b0}}, s0_sample_r};
    acc_seed   = samp_ext << shift_r;
    acc_sum    = {1'b0, acc_r} - {1'b0, (acc_r >> shift_r)} + {1'b0, samp_ext};
    acc_nxt    = (acc_r == '0) ? acc_seed : acc_sum[ACC_W-1:0];
    acc_scaled = acc_nxt >> shift_r;
    if (acc_scaled > {{spp_pkg::ACC_EXTRA{1'b0}}, FULL_SCALE}) begin
      smoothed = FULL_SCALE;
    end else begin
      smoothed = acc_scaled[SAMPLE_BITS-1:0];
    end
    level_base = (held_level_r == '0) ? smoothed : held_level_r;
    level_diff = (smoothed > level_base) ? (smoothed - level_base)
                                         : (level_base - smoothed);
    level_diff_ext = CMP_W'(level_diff);
    level_db_ext   = CMP_W'(level_db_r);
    held_level_nxt = (level_diff_ext >= level_db_ext) ? smoothed : level_base;
  end

  // Angle stage: floor(held * 180 / full scale) with one correction step
  logic [PROD_W-1:0]           angle_prod;
  logic [spp_pkg::ANGLE_W-1:0] angle_q0;
  logic [SAMPLE_BITS:0]        angle_rem;
  logic [spp_pkg::ANGLE_W:0]   angle_q;
  logic [spp_pkg::ANGLE_W-1:0] angle_nxt;
  logic [FMT_W-1:0]            smoothed_fmt;

  always_comb begin
    angle_prod = {{spp_pkg::ANGLE_W{1'b0}}, held_level_r}
                 * PROD_W'(spp_pkg::ANGLE_MAX);
    angle_q0   = angle_prod[PROD_W-1:SAMPLE_BITS];
    angle_rem  = {1'b0, angle_prod[SAMPLE_BITS-1:0]}
                 + (SAMPLE_BITS+1)'(angle_q0);
    angle_q    = {1'b0, angle_q0} + {{spp_pkg::ANGLE_W{1'b0}}, (angle_rem >= FS_EXT)};
    angle_nxt  = (angle_q > {1'b0, spp_pkg::ANGLE_MAX}) ? spp_pkg::ANGLE_MAX
                                                        : angle_q[spp_pkg::ANGLE_W-1:0];
    smoothed_fmt = {{spp_pkg::LEVEL_W{1'b0}}, s1_smoothed_r};
  end

  // Output stage: map angle to pulse, apply pulse deadband
  logic [spp_pkg::PULSE_PROD_W-1:0] pulse_prod;
  logic [spp_pkg::PULSE_W-1:0]      pulse_new;
  logic [spp_pkg::PULSE_W-1:0]      pulse_diff;
  logic                             pulse_chg;

  always_comb begin
    pulse_prod = {{spp_pkg::PULSE_MUL_W{1'b0}}, s2_angle_r}
                 * {{spp_pkg::ANGLE_W{1'b0}}, spp_pkg::PULSE_MUL};
    pulse_new  = spp_pkg::PULSE_MIN
                 + pulse_prod[spp_pkg::PULSE_MUL_SHIFT +: spp_pkg::PULSE_W];
    pulse_diff = (pulse_new > held_pulse_r) ? (pulse_new - held_pulse_r)
                                            : (held_pulse_r - pulse_new);
    pulse_chg  = (pulse_diff >= {1'b0, pulse_db_r});
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= spp_pkg::SHIFT_RESET;
      level_db_r <= spp_pkg::LEVEL_DB_RESET;
      pulse_db_r <= spp_pkg::PULSE_DB_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        spp_pkg::CFG_SMOOTHING_SHIFT: shift_r    <= cfg_data[spp_pkg::SHIFT_W-1:0];
        spp_pkg::CFG_LEVEL_DEADBAND:  level_db_r <= cfg_data[spp_pkg::LEVEL_DB_W-1:0];
        spp_pkg::CFG_PULSE_DEADBAND:  pulse_db_r <= cfg_data[spp_pkg::PULSE_DB_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance valid flags and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      acc_r        <= '0;
      held_level_r <= '0;
      held_pulse_r <= spp_pkg::PULSE_CENTRE;
    end else begin
      if (s0_rdy)  s0_valid_r  <= in_tvalid;
      if (s1_rdy)  s1_valid_r  <= s0_valid_r;
      if (s2_rdy)  s2_valid_r  <= s1_valid_r;
      if (out_rdy) out_valid_r <= s2_valid_r;
      if (s1_load) begin
        acc_r        <= acc_nxt;
        held_level_r <= held_level_nxt;
      end
      if (out_load && pulse_chg) begin
        held_pulse_r <= pulse_new;
      end
    end
  end

  // Hold payload until each stage hands its transaction on
  always_ff @(posedge clk) begin
    if (s0_load)  s0_sample_r   <= in_tdata[SAMPLE_BITS-1:0];
    if (s1_load)  s1_smoothed_r <= smoothed;
    if (s2_load) begin
      s2_angle_r    <= angle_nxt;
      s2_smoothed_r <= smoothed_fmt[spp_pkg::LEVEL_W-1:0];
    end
    if (out_load) begin
      out_changed_r  <= pulse_chg;
      out_angle_r    <= s2_angle_r;
      out_smoothed_r <= s2_smoothed_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_smoothed_r, out_angle_r, held_pulse_r};
  assign out_tuser  = out_changed_r;

  // Accumulator never grows past full scale times the widest weight
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= ACC_MAX)
    else $error("accumulator exceeded its bound");

  // Held pulse stays inside the servo range
  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_pulse_r >= spp_pkg::PULSE_MIN && held_pulse_r <= spp_pkg::PULSE_MAX)
    else $error("held pulse out of range");

  // A zero held level only follows a zero smoothed value
  a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && held_level_r == '0) |-> (s1_smoothed_r == '0))
    else $error("held level left at zero after a nonzero sample");

  // Angle stage never exceeds the mechanical range
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_angle_r <= spp_pkg::ANGLE_MAX))
    else $error("angle above range");

  // A reported change with a nonzero deadband moved the held pulse
  a_change_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && pulse_chg && pulse_db_r != '0)
      |=> (held_pulse_r != $past(held_pulse_r)))
    else $error("pulse change flagged without a pulse move");

endmodule

// ===== dv/servo_pot_pulse_conditioner_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pot_pulse_conditioner_checker
// Watches the configuration port and both streams of the pulse conditioner,
// predicts each result from the accepted samples and compares it, field by
// field and in order, with what the block returns.
// ----------------------------------------------------------------------------
module servo_pot_pulse_conditioner_checker #(
  parameter int SAMPLE_W = spp_pkg::SAMPLE_BITS_DEF,
  parameter int IN_W     = ((spp_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [spp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [spp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            out_tuser,
  output int                              mismatch_count,
  output int                              pending_count
);

  localparam int ACC_W      = SAMPLE_W + spp_pkg::ACC_EXTRA;
  localparam int FULL_SCALE = (1 << SAMPLE_W) - 1;

  typedef struct {
    logic [spp_pkg::PULSE_W-1:0] pulse_width;
    logic                        pulse_changed;
    logic [spp_pkg::ANGLE_W-1:0] angle_degrees;
    logic [spp_pkg::LEVEL_W-1:0] smoothed_level;
  } pulse_result_t;

  // Predicted configuration and state
  logic [spp_pkg::SHIFT_W-1:0]    smooth_shift;
  logic [spp_pkg::LEVEL_DB_W-1:0] level_db;
  logic [spp_pkg::PULSE_DB_W-1:0] pulse_db;
  logic [ACC_W-1:0]               avg_acc;
  logic [SAMPLE_W-1:0]            held_level;
  logic [spp_pkg::PULSE_W-1:0]    held_pulse;

  pulse_result_t expected_results[$];
  int            result_index;

  // Print one line per mismatch, count every one
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s (result %0d): got %0d, expected %0d",
             what, result_index, got, want);
    mismatch_count++;
  endtask

  // Advance the average, the held level and the held pulse by one sample
  function automatic pulse_result_t condition_sample(input logic [SAMPLE_W-1:0] sample);
    pulse_result_t res;
    int            smoothed;
    int            angle;
    int            pulse;
    int            level_diff;
    int            pulse_diff;
    if (avg_acc == '0)
      avg_acc = ACC_W'(sample) << smooth_shift;
    else
      avg_acc = avg_acc - (avg_acc >> smooth_shift) + ACC_W'(sample);
    smoothed = int'(avg_acc >> smooth_shift);
    if (smoothed > FULL_SCALE)
      smoothed = FULL_SCALE;

    // A zero held level takes the smoothed value first
    if (held_level == '0)
      held_level = SAMPLE_W'(smoothed);
    level_diff = smoothed - int'(held_level);
    if (level_diff < 0)
      level_diff = -level_diff;
    if (level_diff >= int'(level_db))
      held_level = SAMPLE_W'(smoothed);

    angle = (int'(held_level) * int'(spp_pkg::ANGLE_MAX)) / FULL_SCALE;
    if (angle > int'(spp_pkg::ANGLE_MAX))
      angle = int'(spp_pkg::ANGLE_MAX);
    pulse = int'(spp_pkg::PULSE_MIN)
            + (angle * (int'(spp_pkg::PULSE_MAX) - int'(spp_pkg::PULSE_MIN)))
              / int'(spp_pkg::ANGLE_MAX);

    pulse_diff = pulse - int'(held_pulse);
    if (pulse_diff < 0)
      pulse_diff = -pulse_diff;
    res.pulse_changed = 1'b0;
    if (pulse_diff >= int'(pulse_db)) begin
      held_pulse        = spp_pkg::PULSE_W'(pulse);
      res.pulse_changed = 1'b1;
    end

    res.pulse_width    = held_pulse;
    res.angle_degrees  = spp_pkg::ANGLE_W'(angle);
    res.smoothed_level = spp_pkg::LEVEL_W'(smoothed);
    return res;
  endfunction

  // Track writes, predict on accepted samples, compare accepted results
  always @(posedge clk) begin
    pulse_result_t want;
    logic [spp_pkg::PULSE_W-1:0] got_pulse;
    logic [spp_pkg::ANGLE_W-1:0] got_angle;
    logic [spp_pkg::LEVEL_W-1:0] got_level;
    if (!rst_n) begin
      smooth_shift   = spp_pkg::SHIFT_RESET;
      level_db       = spp_pkg::LEVEL_DB_RESET;
      pulse_db       = spp_pkg::PULSE_DB_RESET;
      avg_acc        = '0;
      held_level     = '0;
      held_pulse     = spp_pkg::PULSE_CENTRE;
      mismatch_count = 0;
      result_index   = 0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          spp_pkg::CFG_SMOOTHING_SHIFT:
            smooth_shift = cfg_data[spp_pkg::SHIFT_W-1:0];
          spp_pkg::CFG_LEVEL_DEADBAND:
            level_db = cfg_data[spp_pkg::LEVEL_DB_W-1:0];
          spp_pkg::CFG_PULSE_DEADBAND:
            pulse_db = cfg_data[spp_pkg::PULSE_DB_W-1:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready)
        expected_results.push_back(condition_sample(in_tdata[SAMPLE_W-1:0]));

      if (out_tvalid && out_tready) begin
        got_pulse = out_tdata[spp_pkg::PULSE_W-1:0];
        got_angle = out_tdata[spp_pkg::PULSE_W +: spp_pkg::ANGLE_W];
        got_level = out_tdata[spp_pkg::PULSE_W+spp_pkg::ANGLE_W +: spp_pkg::LEVEL_W];
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, pulse_width", got_pulse, 0);
        end else begin
          want = expected_results.pop_front();
          if (got_pulse !== want.pulse_width)
            report_mismatch("pulse_width", got_pulse, want.pulse_width);
          if (out_tuser !== want.pulse_changed)
            report_mismatch("pulse_changed", out_tuser, want.pulse_changed);
          if (got_angle !== want.angle_degrees)
            report_mismatch("angle_degrees", got_angle, want.angle_degrees);
          if (got_level !== want.smoothed_level)
            report_mismatch("smoothed_level", got_level, want.smoothed_level);
        end
        result_index++;
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== dv/servo_pot_pulse_conditioner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pot_pulse_conditioner_tb
// Drives samples and register writes into the pulse conditioner with random
// gaps and output stalls; a checker beside the block predicts and compares
// every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module servo_pot_pulse_conditioner_tb;

  localparam int SAMPLE_W    = spp_pkg::SAMPLE_BITS_DEF;
  localparam int IN_W        = ((spp_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int FULL_SCALE  = (1 << SAMPLE_W) - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 120;
  localparam int SETTLE      = 8;

  // No register sits at this index; writes to it must be ignored
  localparam logic [spp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [spp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [spp_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            in_tvalid;
  logic                            in_tready;
  // [11:0] sample, upper bits zero
  logic [IN_W-1:0]                 in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  // [11:0] pulse_width, [19:12] angle_degrees, [31:20] smoothed_level
  logic [spp_pkg::OUT_DATA_W-1:0]  out_tdata;
  // [0] pulse_changed
  logic                            out_tuser;

  int mismatch_count;
  int pending_count;
  int cycle_count;
  int in_idle_pct;
  int out_idle_pct;

  servo_pot_pulse_conditioner #(.SAMPLE_BITS(SAMPLE_W)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  servo_pot_pulse_conditioner_checker #(.SAMPLE_W(SAMPLE_W), .IN_W(IN_W)) conditioner_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .mismatch_count(mismatch_count), .pending_count(pending_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Known values on every input from time zero
  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = spp_pkg::CFG_SMOOTHING_SHIFT;
    cfg_data     = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    in_idle_pct  = 25;
    out_idle_pct = 25;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct)
      return 0;
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Stall the result side at random
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = pick_gap(out_idle_pct);
      if (gap == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  // Offer one sample after a random gap, hold it until accepted
  task automatic send_sample(input int value);
    int gap;
    gap = pick_gap(in_idle_pct);
    repeat (gap) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(value[SAMPLE_W-1:0]);
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every result is back and the pipe is quiet
  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [spp_pkg::CFG_INDEX_W-1:0] index,
                           input logic [spp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  function automatic int clamp_sample(input int v);
    if (v < 0)
      return 0;
    if (v > FULL_SCALE)
      return FULL_SCALE;
    return v;
  endfunction

  // Stimulus and verdict
  initial begin
    int shift_val;
    int level_val;
    int pulse_val;
    int mode;
    int burst;
    int target;
    int step;
    int sent;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Reset settings: zero samples on an empty accumulator, then seeding
    send_sample(0);
    send_sample(0);
    send_sample(FULL_SCALE);
    send_sample(FULL_SCALE);
    send_sample(1);
    send_sample(2048);
    send_sample(2060);

    // No smoothing, no deadbands: every sample counts as a pulse change
    drain();
    write_reg(spp_pkg::CFG_SMOOTHING_SHIFT, 12'd0);
    write_reg(spp_pkg::CFG_LEVEL_DEADBAND, 12'd0);
    write_reg(spp_pkg::CFG_PULSE_DEADBAND, 12'd0);
    send_sample(FULL_SCALE);
    send_sample(FULL_SCALE);
    send_sample(0);
    send_sample(0);
    send_sample(1);
    send_sample(2047);

    // Heaviest smoothing, register data with junk above the field
    drain();
    write_reg(spp_pkg::CFG_SMOOTHING_SHIFT, 12'hFFF);
    write_reg(spp_pkg::CFG_LEVEL_DEADBAND, 12'd12);
    write_reg(spp_pkg::CFG_PULSE_DEADBAND, 12'd8);
    send_sample(FULL_SCALE);
    send_sample(FULL_SCALE);
    send_sample(FULL_SCALE);

    // Lower the shift to zero while running: the average follows each sample
    drain();
    write_reg(spp_pkg::CFG_SMOOTHING_SHIFT, 12'd0);
    send_sample(FULL_SCALE);
    send_sample(FULL_SCALE);
    send_sample(100);

    // Widest deadbands, masked pulse deadband, write to an unused index
    drain();
    write_reg(spp_pkg::CFG_LEVEL_DEADBAND, 12'hFFF);
    write_reg(spp_pkg::CFG_PULSE_DEADBAND, 12'hFFF);
    write_reg(CFG_UNUSED_INDEX, 12'h000);
    send_sample(0);
    send_sample(FULL_SCALE);
    send_sample(2000);

    // Random phases, each with its own settings and idling
    target = 2048;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase == 0)
        shift_val = 0;
      else if (phase == 1)
        shift_val = 7;
      else
        shift_val = $urandom_range(0, 7);
      case ($urandom_range(0, 9))
        0:       level_val = 0;
        1:       level_val = FULL_SCALE;
        2:       level_val = $urandom_range(0, FULL_SCALE);
        default: level_val = $urandom_range(1, 60);
      endcase
      case ($urandom_range(0, 9))
        0:       pulse_val = 0;
        1:       pulse_val = 2000;
        2:       pulse_val = $urandom_range(0, 4095);
        default: pulse_val = $urandom_range(1, 40);
      endcase
      if ($urandom_range(0, 3) == 0)
        shift_val = shift_val | ($urandom_range(1, 511) << spp_pkg::SHIFT_W);
      write_reg(spp_pkg::CFG_SMOOTHING_SHIFT, spp_pkg::CFG_DATA_W'(shift_val));
      write_reg(spp_pkg::CFG_LEVEL_DEADBAND, spp_pkg::CFG_DATA_W'(level_val));
      write_reg(spp_pkg::CFG_PULSE_DEADBAND, spp_pkg::CFG_DATA_W'(pulse_val));
      if ($urandom_range(0, 4) == 0)
        write_reg(CFG_UNUSED_INDEX, spp_pkg::CFG_DATA_W'($urandom_range(0, 4095)));

      if (phase % 3 == 0) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = $urandom_range(10, 60);
        out_idle_pct = $urandom_range(10, 60);
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        mode  = $urandom_range(0, 3);
        burst = $urandom_range(10, 30);
        step  = $urandom_range(1, 40);
        if ($urandom_range(0, 1) == 0)
          step = -step;
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          case (mode)
            // Full-range noise
            0: send_sample($urandom_range(0, FULL_SCALE));
            // Knob held near a point with jitter
            1: begin
              if (k == 0)
                target = $urandom_range(0, FULL_SCALE);
              send_sample(clamp_sample(target + $urandom_range(0, 16) - 8));
            end
            // Ends of travel
            2: begin
              case ($urandom_range(0, 3))
                0:       send_sample(0);
                1:       send_sample(FULL_SCALE);
                2:       send_sample($urandom_range(0, 3));
                default: send_sample(FULL_SCALE - $urandom_range(0, 3));
              endcase
            end
            // Slow sweep
            default: begin
              target = clamp_sample(target + step);
              send_sample(target);
            end
          endcase
          sent++;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
